// ===== rtl/core/nv_transfer_sequencer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// nv transfer sequencer assertion macros
// shared property forms for the sequencer checks
// ---------------------------------------------------------------------------
`ifndef NV_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define NV_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define NVTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nvts assertion failed");

// next-cycle implication
`define NVTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nvts assertion failed");

`endif

// ===== rtl/core/nvts_pkg.sv =====
// ---------------------------------------------------------------------------
// nvts_pkg
// types and codes shared by the nv transfer sequencer
// ---------------------------------------------------------------------------
package nvts_pkg;

  typedef enum logic [2:0] {
    FN_TICK        = 3'd0,
    FN_START_WRITE = 3'd1,
    FN_START_READ  = 3'd2,
    FN_COMPLETION  = 3'd3,
    FN_RELEASE     = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_XFER = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_WR   = 2'd1,
    MODE_RD   = 2'd2
  } mode_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOTICE = 2'd3;

  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;
  localparam logic [7:0] WAIT_LIMIT_RESET  = 8'd10;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;

  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_WAIT_LIMIT  = 1'b1;

  typedef struct packed {
    phase_t      phase;
    mode_t       mode;
    logic        awaiting;
    logic [7:0]  wait_ticks;
    logic [7:0]  failure_count;
    logic [31:0] host_address;
    logic [31:0] nv_offset;
    logic [15:0] total_bytes;
    logic [16:0] remaining;
    logic [15:0] moved_bytes;
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] buffer_address;
    logic [31:0] device_offset;
    logic [15:0] length;
    logic [15:0] done_count;
  } seq_item_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [7:0] wait_limit;
  } seq_cfg_t;

  localparam seq_state_t STATE_RESET = '{
    phase:         PH_IDLE,
    mode:          MODE_NONE,
    awaiting:      1'b0,
    wait_ticks:    8'd0,
    failure_count: 8'd0,
    host_address:  32'd0,
    nv_offset:     32'd0,
    total_bytes:   16'd0,
    remaining:     17'd0,
    moved_bytes:   16'd0
  };

endpackage

// ===== rtl/core/nvts_step.sv =====
// ---------------------------------------------------------------------------
// nvts_step
// next-state and result logic for one sequencer transaction
// ---------------------------------------------------------------------------
module nvts_step
  import nvts_pkg::*;
(
  input  seq_state_t state,
  input  seq_item_t  item,
  input  seq_cfg_t   cfg,
  output seq_state_t state_next,
  output logic [1:0] kind_next
);

  logic [15:0] moved_sum;
  logic [16:0] rem_calc;
  logic        rem_pos;
  logic        rem_zero;
  logic        cur_rem_pos;
  logic        cur_rem_zero;

  assign moved_sum    = state.moved_bytes + item.done_count;
  assign rem_calc     = {1'b0, state.total_bytes} - {1'b0, moved_sum};
  assign rem_zero     = (rem_calc == 17'd0);
  assign rem_pos      = !rem_calc[16] && !rem_zero;
  assign cur_rem_zero = (state.remaining == 17'd0);
  assign cur_rem_pos  = !state.remaining[16] && !cur_rem_zero;

  always_comb begin
    state_next = state;
    kind_next  = KIND_STATUS;
    case (item.func)
      FN_TICK: begin
        case (state.phase)
          PH_IDLE: begin
            if (state.mode != MODE_NONE) begin
              state_next.phase = PH_XFER;
            end
          end
          PH_XFER: begin
            if (!state.awaiting) begin
              state_next.wait_ticks = 8'd0;
              if (state.failure_count > cfg.retry_limit) begin
                state_next.phase = PH_ERR;
              end else if (cur_rem_pos) begin
                state_next.awaiting = 1'b1;
                if (state.mode == MODE_WR) begin
                  kind_next = KIND_WRITE;
                end else if (state.mode == MODE_RD) begin
                  kind_next = KIND_READ;
                end
              end else if (cur_rem_zero) begin
                state_next.phase = PH_DONE;
              end
            end else begin
              if (state.wait_ticks != COUNT_MAX) begin
                state_next.wait_ticks = state.wait_ticks + 8'd1;
              end
              if (state.wait_ticks > cfg.wait_limit) begin
                state_next.phase = PH_ERR;
              end
            end
          end
          PH_DONE: begin
            kind_next        = KIND_NOTICE;
            state_next.phase = PH_XFER;
          end
          default: begin
          end
        endcase
      end
      FN_START_WRITE, FN_START_READ: begin
        if (item.length != 16'd0) begin
          state_next.host_address = item.buffer_address;
          state_next.nv_offset    = item.device_offset;
          state_next.total_bytes  = item.length;
          state_next.remaining    = {1'b0, item.length};
          state_next.moved_bytes  = 16'd0;
          state_next.mode = (item.func == FN_START_WRITE) ? MODE_WR : MODE_RD;
        end
      end
      FN_COMPLETION: begin
        if (item.done_count != 16'd0) begin
          state_next.moved_bytes = moved_sum;
          state_next.remaining   = rem_calc;
          if (rem_pos) begin
            state_next.host_address = state.host_address + {16'd0, item.done_count};
            state_next.nv_offset    = state.nv_offset + {16'd0, item.done_count};
          end else if (rem_zero) begin
            state_next.moved_bytes = 16'd0;
          end
          state_next.failure_count = 8'd0;
        end else if (state.failure_count != COUNT_MAX) begin
          state_next.failure_count = state.failure_count + 8'd1;
        end
        state_next.awaiting = 1'b0;
      end
      FN_RELEASE: begin
        state_next.phase        = PH_IDLE;
        state_next.mode         = MODE_NONE;
        state_next.awaiting     = 1'b0;
        state_next.host_address = 32'd0;
        state_next.nv_offset    = 32'd0;
        state_next.total_bytes  = 16'd0;
        state_next.remaining    = 17'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/nv_transfer_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// nv_transfer_sequencer_unit
// chunked nv memory transfer sequencer, one result per transaction
// registers: input reg, then result reg, from request accept to result valid
// throughput: 1 transaction per cycle while rsp_stall does not hold the result, set by the state update
// reset: synchronous, clears sequencer state, pipeline valids, limits to 3 / 10
// ---------------------------------------------------------------------------
`include "nv_transfer_sequencer_unit_macros.svh"

module nv_transfer_sequencer_unit
  import nvts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         func,
  input  logic [31:0]        buffer_address,
  input  logic [31:0]        device_offset,
  input  logic [15:0]        length,
  input  logic [15:0]        done_count,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         kind,
  output logic [31:0]        cmd_buffer_address,
  output logic [31:0]        cmd_device_offset,
  output logic signed [16:0] cmd_remaining,
  output logic [1:0]         machine_state,
  output logic               busy_res
);

  seq_cfg_t   cfg;
  seq_state_t state;
  seq_state_t state_next;
  seq_item_t  item;
  logic       item_valid;
  logic [1:0] kind_next;
  logic       advance;

  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit <= RETRY_LIMIT_RESET;
      cfg.wait_limit  <= WAIT_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_RETRY_LIMIT) begin
        cfg.retry_limit <= cfg_data;
      end else begin
        cfg.wait_limit <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= '{func, buffer_address, device_offset, length, done_count};
    end
  end

  nvts_step u_step (
    .state      (state),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next),
    .kind_next  (kind_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind               <= kind_next;
      cmd_buffer_address <= state_next.host_address;
      cmd_device_offset  <= state_next.nv_offset;
      cmd_remaining      <= state_next.remaining;
      machine_state      <= state_next.phase;
      busy_res           <= (state_next.mode != MODE_NONE);
    end
  end

  `NVTS_ASSERT_IMPLIES(a_chunk_in_xfer, clk, rst, rsp_valid && (kind == KIND_WRITE || kind == KIND_READ), machine_state == PH_XFER && busy_res)
  `NVTS_ASSERT_IMPLIES(a_notice_in_xfer, clk, rst, rsp_valid && kind == KIND_NOTICE, machine_state == PH_XFER)
  `NVTS_ASSERT_NEXT(a_state_held_on_stall, clk, rst, rsp_valid && rsp_stall, $stable(state))

endmodule
